// File: hw/rtl/shfe_pkg.sv
// ============================================================================
// shfe_pkg - shared types and constants of the strip hit fragment encoder
// Halfword codes, link mapping and hit address formatting.
// ============================================================================
package shfe_pkg;

    localparam int STRIP_W       = 10;
    localparam int GROUP_W       = 8;
    localparam int FIBRE_W       = 7;
    localparam int LINK_W        = 7;
    localparam int HALF_W        = 16;
    localparam int WORD_W        = 2 * HALF_W;

    localparam int MAX_GROUP       = 128;
    localparam int STRIPS_PER_CHIP = 128;
    localparam int CHIP_SHIFT      = $clog2(STRIPS_PER_CHIP);
    localparam int LINKS_PER_FMT   = 12;
    localparam int STRIP_COUNT     = 768;

    localparam logic [STRIP_W-1:0] LAST_STRIP = STRIP_W'(STRIP_COUNT - 1);
    localparam logic [STRIP_W-1:0] PAIR_BASE  = STRIP_W'(STRIP_COUNT - 2);

    // reciprocal of LINKS_PER_FMT, exact for every 7-bit fibre number
    localparam int RECIP_MUL   = 171;
    localparam int RECIP_SHIFT = 11;

    localparam logic [HALF_W-1:0] HDR_BASE   = 16'h2000;
    localparam logic [HALF_W-1:0] TRAILER    = 16'h4000;
    localparam logic [HALF_W-1:0] HIT_SINGLE = 16'h8000;
    localparam logic [HALF_W-1:0] HIT_PAIR   = 16'h8001;
    localparam logic [HALF_W-1:0] TB_FILL    = 16'h8088;
    localparam logic [HALF_W-1:0] TB_EVEN    = 16'h8008;

    // halfword request from the sequencer to the packer
    typedef struct packed {
        logic              push;
        logic [HALF_W-1:0] half;
        logic              finish;
    } pk_req_t;

    // packer status back to the sequencer
    typedef struct packed {
        logic push_ok;
        logic finish_ok;
        logic pend_valid;
        logic hold_valid;
    } pk_status_t;

    // fibre -> {formatter[2:0], link within formatter[3:0]}
    function automatic logic [LINK_W-1:0] fibre_to_link(input logic [FIBRE_W-1:0] fibre);
        logic [15:0] prod;
        logic [2:0]  fmt;
        logic [6:0]  base;
        logic [6:0]  diff;
        prod = 16'(fibre) * 16'(RECIP_MUL);
        fmt  = prod[RECIP_SHIFT +: 3];
        base = 7'(fmt) * 7'(LINKS_PER_FMT);
        diff = fibre - base;
        return {fmt, diff[3:0]};
    endfunction

    // side, chip and strip-within-chip fields of a hit word
    function automatic logic [HALF_W-1:0] hit_addr(input logic [STRIP_W-1:0] t,
                                                   input logic              side);
        return {1'b0, side, t[CHIP_SHIFT +: 3], t[CHIP_SHIFT-1:0], 4'b0000};
    endfunction

endpackage

// File: hw/rtl/shfe_word_packer.sv
// ============================================================================
// shfe_word_packer - halfword pairing and output stage
// Pairs halfwords big-half-first, holds one finished word until the item's
// end is known so that its last flag is right, and drives the output channel.
// ============================================================================
module shfe_word_packer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  shfe_pkg::pk_req_t            req,
    output shfe_pkg::pk_status_t         st,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [shfe_pkg::WORD_W-1:0]  word,
    output logic                         last
);

    logic [shfe_pkg::HALF_W-1:0] pend_half_reg;
    logic                        pend_valid_reg;
    logic [shfe_pkg::WORD_W-1:0] hold_word_reg;
    logic                        hold_valid_reg;
    logic [shfe_pkg::WORD_W-1:0] out_word_reg;
    logic                        out_last_reg;
    logic                        out_valid_reg;

    logic out_free;
    logic push_ok;
    logic finish_ok;
    logic do_push;
    logic do_finish;
    logic pair_done;
    logic load_out;

    assign out_free  = !out_valid_reg || out_ready;
    assign push_ok   = !(pend_valid_reg && hold_valid_reg && !out_free);
    assign finish_ok = !hold_valid_reg || out_free;
    assign do_push   = req.push && push_ok;
    assign do_finish = req.finish && finish_ok;
    assign pair_done = do_push && pend_valid_reg;
    assign load_out  = (pair_done && hold_valid_reg) || (do_finish && hold_valid_reg);

    assign st.push_ok    = push_ok;
    assign st.finish_ok  = finish_ok;
    assign st.pend_valid = pend_valid_reg;
    assign st.hold_valid = hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
                pend_valid_reg <= !pend_valid_reg;
            if (pair_done)
                hold_valid_reg <= 1'b1;
            else if (do_finish)
                hold_valid_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && !pend_valid_reg)
            pend_half_reg <= req.half;
        if (pair_done)
            hold_word_reg <= {pend_half_reg, req.half};
        if (load_out)
        begin
            out_word_reg <= hold_word_reg;
            out_last_reg <= do_finish;
        end
    end

    assign out_valid = out_valid_reg;
    assign word      = out_word_reg;
    assign last      = out_last_reg;

endmodule

// File: hw/rtl/strip_hit_fragment_encoder.sv
// ============================================================================
// strip_hit_fragment_encoder - strip cluster hits to 32-bit readout words
// Link header/trailer insertion, condensed or expanded hit encoding and
// big-half-first packing of 16-bit halfwords.
// ============================================================================
// One item is handled at a time. The accept cycle maps the fibre to its link
// and clamps the cluster, then a sequencer issues one halfword per cycle
// through a single shared address unit (one subtract for the reversed strip
// order plus field packing): an optional trailer and header, then the hit
// halfwords, then a closing step that releases the last word of the item.
// Per item, apart from any link trailer and header, the halfword counts are:
// a condensed cluster of g strips issues about g/2 halfwords (one more per
// chip boundary crossed), an expanded cluster about g/2 + 1, and an end of
// fragment at most two. A finished word waits in a hold register until the
// next word or the end of the item settles its last flag, then moves to the
// output register. The sequencer stalls only when a word completes, or the
// item closes, while both of these registers are full and the consumer is
// not taking the output word. The configuration register is written through
// its own channel, which is always ready; write it only while the block is
// idle.
module strip_hit_fragment_encoder (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [6:0]                    fibre,
    input  logic                          module_side,
    input  logic [9:0]                    strip,
    input  logic [7:0]                    group_size,
    input  logic [2:0]                    time_bin,
    input  logic                          first_hit_error,
    input  logic                          second_hit_error,
    input  logic                          swap_readout,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   word,
    output logic                          last
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLOSE  = 8'b0000_0010,
        ST_HEAD   = 8'b0000_0100,
        ST_HIT    = 8'b0000_1000,
        ST_FILL   = 8'b0001_0000,
        ST_EVEN   = 8'b0010_0000,
        ST_PAD    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    localparam int FILL_W = shfe_pkg::GROUP_W - 1;

    state_t state_reg, state_next;

    logic                           condensed_mode_reg;
    logic [shfe_pkg::LINK_W-1:0]    open_link_reg,  open_link_next;
    logic                           link_open_reg,  link_open_next;

    // item registers
    logic                           req_reg;
    logic [shfe_pkg::LINK_W-1:0]    link_reg;
    logic [shfe_pkg::STRIP_W-1:0]   last_reg;
    logic [shfe_pkg::GROUP_W-1:0]   g_reg;
    logic [2:0]                     tb_reg;
    logic                           e1_reg;
    logic                           e2_reg;
    logic                           swap_reg;
    logic [shfe_pkg::STRIP_W-1:0]   p_reg,    p_next;
    logic [FILL_W-1:0]              fill_reg, fill_next;

    // accept-cycle decode
    logic [shfe_pkg::LINK_W-1:0]    link_in;
    logic [shfe_pkg::STRIP_W-1:0]   s_sat;
    logic [shfe_pkg::STRIP_W-1:0]   room;
    logic [shfe_pkg::GROUP_W-1:0]   g_min;
    logic [shfe_pkg::GROUP_W-1:0]   g_max;
    logic [shfe_pkg::GROUP_W-1:0]   g_clamp;
    logic                           accept;
    logic                           link_change;

    // shared address unit
    logic                           pair;
    logic                           seg_done;
    logic [shfe_pkg::STRIP_W-1:0]   addr_base;
    logic [shfe_pkg::STRIP_W-1:0]   addr_strip;
    logic [shfe_pkg::HALF_W-1:0]    addr_bits;

    shfe_pkg::pk_req_t              pk_req;
    shfe_pkg::pk_status_t           pk_st;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // -------------------------------------------------------------------------
    // Accept decode: link number and cluster clamp
    // -------------------------------------------------------------------------
    always_comb
    begin
        link_in = shfe_pkg::fibre_to_link(fibre);
        s_sat   = (strip > shfe_pkg::LAST_STRIP) ? shfe_pkg::LAST_STRIP : strip;
        room    = shfe_pkg::STRIP_W'(shfe_pkg::STRIP_COUNT) - s_sat;
        g_min   = (group_size == '0) ? shfe_pkg::GROUP_W'(1) : group_size;
        g_max   = (9'(g_min) > 9'(shfe_pkg::MAX_GROUP))
                  ? shfe_pkg::GROUP_W'(shfe_pkg::MAX_GROUP) : g_min;
        g_clamp = (shfe_pkg::STRIP_W'(g_max) > room) ? room[shfe_pkg::GROUP_W-1:0] : g_max;
        link_change = !link_open_reg || (open_link_reg != link_in);
    end

    // -------------------------------------------------------------------------
    // Shared address unit: reversed strip order and hit word fields
    // -------------------------------------------------------------------------
    always_comb
    begin
        pair     = (p_reg != last_reg) && (p_reg[shfe_pkg::CHIP_SHIFT-1:0] != '1);
        seg_done = pair ? ((p_reg + 1'b1) == last_reg) : (p_reg == last_reg);
        if (condensed_mode_reg)
            addr_base = pair ? shfe_pkg::PAIR_BASE : shfe_pkg::LAST_STRIP;
        else
            addr_base = shfe_pkg::STRIP_W'(shfe_pkg::STRIP_COUNT)
                        - shfe_pkg::STRIP_W'(g_reg);
        addr_strip = swap_reg ? (addr_base - p_reg) : p_reg;
        addr_bits  = shfe_pkg::hit_addr(addr_strip, link_reg[0]);
    end

    // -------------------------------------------------------------------------
    // Sequencer
    // -------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        open_link_next = open_link_reg;
        link_open_next = link_open_reg;
        p_next         = p_reg;
        fill_next      = fill_reg;
        in_ready       = 1'b0;
        pk_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        // end of fragment: close an open link, then pad an unpaired halfword
                        link_open_next = 1'b0;
                        open_link_next = '0;
                        if (link_open_reg)
                            state_next = ST_CLOSE;
                        else if (pk_st.pend_valid)
                            state_next = ST_PAD;
                        else
                            state_next = ST_FINISH;
                    end
                    else
                    begin
                        p_next    = s_sat;
                        fill_next = FILL_W'((g_clamp - 1'b1) >> 1);
                        if (!link_change)
                            state_next = ST_HIT;
                        else if (link_open_reg)
                            state_next = ST_CLOSE;
                        else
                            state_next = ST_HEAD;
                    end
                end
            end
            ST_CLOSE:
            begin
                pk_req.push = 1'b1;
                pk_req.half = shfe_pkg::TRAILER;
                if (pk_st.push_ok)
                begin
                    if (!req_reg)
                        state_next = ST_HEAD;
                    else if (pk_st.pend_valid)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_PAD;
                end
            end
            ST_HEAD:
            begin
                pk_req.push = 1'b1;
                pk_req.half = shfe_pkg::HDR_BASE
                              | shfe_pkg::HALF_W'({condensed_mode_reg, 8'h00})
                              | shfe_pkg::HALF_W'(link_reg);
                if (pk_st.push_ok)
                begin
                    open_link_next = link_reg;
                    link_open_next = 1'b1;
                    state_next     = ST_HIT;
                end
            end
            ST_HIT:
            begin
                pk_req.push = 1'b1;
                if (condensed_mode_reg)
                begin
                    if (pair)
                        pk_req.half = shfe_pkg::HIT_PAIR | addr_bits
                                      | shfe_pkg::HALF_W'({e2_reg, e1_reg, 2'b00});
                    else
                        pk_req.half = shfe_pkg::HIT_SINGLE | addr_bits
                                      | shfe_pkg::HALF_W'({e1_reg, 2'b00});
                    if (pk_st.push_ok)
                    begin
                        p_next = p_reg + (pair ? 10'd2 : 10'd1);
                        if (seg_done)
                            state_next = ST_FINISH;
                    end
                end
                else
                begin
                    pk_req.half = shfe_pkg::HIT_SINGLE | addr_bits
                                  | shfe_pkg::HALF_W'(tb_reg);
                    if (pk_st.push_ok)
                    begin
                        if (fill_reg != '0)
                            state_next = ST_FILL;
                        else if (!g_reg[0])
                            state_next = ST_EVEN;
                        else
                            state_next = ST_FINISH;
                    end
                end
            end
            ST_FILL:
            begin
                pk_req.push = 1'b1;
                pk_req.half = shfe_pkg::TB_FILL
                              | shfe_pkg::HALF_W'({tb_reg, 1'b0, tb_reg});
                if (pk_st.push_ok)
                begin
                    fill_next = fill_reg - 1'b1;
                    if (fill_reg == FILL_W'(1))
                        state_next = g_reg[0] ? ST_FINISH : ST_EVEN;
                end
            end
            ST_EVEN:
            begin
                pk_req.push = 1'b1;
                pk_req.half = shfe_pkg::TB_EVEN | shfe_pkg::HALF_W'(tb_reg);
                if (pk_st.push_ok)
                    state_next = ST_FINISH;
            end
            ST_PAD:
            begin
                pk_req.push = 1'b1;
                pk_req.half = shfe_pkg::TRAILER;
                if (pk_st.push_ok)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // release the held word with its last flag
                pk_req.finish = 1'b1;
                if (pk_st.finish_ok)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            condensed_mode_reg <= 1'b0;
            open_link_reg      <= '0;
            link_open_reg      <= 1'b0;
            p_reg              <= '0;
            fill_reg           <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            open_link_reg <= open_link_next;
            link_open_reg <= link_open_next;
            p_reg         <= p_next;
            fill_reg      <= fill_next;
            if (cfg_valid && cfg_ready)
                condensed_mode_reg <= cfg_data;
        end
    end

    // hold the item payload for the whole sequence; module_side has no effect
    // on the words since the encoded side is the link parity
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            link_reg <= link_in;
            g_reg    <= g_clamp;
            last_reg <= s_sat + shfe_pkg::STRIP_W'(g_clamp) - 1'b1;
            tb_reg   <= time_bin;
            e1_reg   <= first_hit_error;
            e2_reg   <= second_hit_error;
            swap_reg <= swap_readout;
        end
    end

    shfe_word_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (pk_req),
        .st        (pk_st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .word      (word),
        .last      (last)
    );

    // -------------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------------
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (fill_reg != '0))
        else $error("time-bin fill entered with empty count");

    a_strip_in_cluster: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HIT) && condensed_mode_reg) |-> (p_reg <= last_reg))
        else $error("condensed walk ran past the cluster end");

    a_head_opens_link: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HEAD) && pk_st.push_ok)
        |=> (link_open_reg && (open_link_reg == link_reg)))
        else $error("header issued without opening its link");

    a_finish_drains: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && pk_st.finish_ok) |=> !pk_st.hold_valid)
        else $error("word still held after the item closed");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pk_st.hold_valid)
        else $error("held word left over between items");

endmodule
